### rtl/ptma_pkg.sv
// Package with constants and types shared by the page table map and allocate block.
package ptma_pkg;
    localparam int VPAGES = 4096;
    localparam int PIDX_W = $clog2(VPAGES);
    localparam int FRAME_W = 20;
    localparam int ENT_W = FRAME_W + 2;
    localparam int CNT_W = 13;
    localparam int PG_W = 20;
    localparam int PADDR_W = 4;

    localparam logic [1:0] OP_XLATE = 2'd0;
    localparam logic [1:0] OP_MAP = 2'd1;
    localparam logic [1:0] OP_UNMAP = 2'd2;
    localparam logic [1:0] OP_ALLOC = 2'd3;

    localparam logic [1:0] REG_KFIRST = 2'd0;
    localparam logic [1:0] REG_KEND = 2'd1;
    localparam logic [1:0] REG_UFIRST = 2'd2;
    localparam logic [1:0] REG_UEND = 2'd3;

    typedef struct packed {
        logic             present;
        logic             user;
        logic [FRAME_W-1:0] frame;
    } t_entry;
endpackage

### rtl/ptma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/page_table_map_and_allocate.sv
// Top level of the page table map and allocate block.
//  channel | dir | handshake            | contents
//  s_axis  | in  | tvalid/tready        | op, virtual address, count, frame, user
//  m_axis  | out | tvalid/tready        | physical address, present, base, status
//  apb     | in  | psel/penable/pready  | four window registers
// After acceptance the block is busy until its result is registered: translate reads one entry,
// map writes count entries, unmap reads count entries and clears those present, and allocate
// scans pages one at a time through the one-read-port page RAM, then writes count entries.
// After reset a clearing pass writes every entry; no item is taken then.
// A result waits in the output register until it is taken; no new transaction is
// accepted while it waits.
module page_table_map_and_allocate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [33:2] vaddr, [46:34] page_count, [66:47] physical_frame
    input  logic [71:0] s_axis_tdata,
    // [0] user_mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] physical_address, [63:32] allocated_base
    output logic [63:0] m_axis_tdata,
    // [0] present, [1] status
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ptma_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptma_pkg::*;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_XLT = 3'd2;
    localparam logic [2:0] S_WR = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_UNM = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] r_state, n_state;
    logic [CNT_W-1:0] r_kf, r_ke, r_uf, r_ue;
    logic [31:0] r_va;
    logic [CNT_W-1:0] r_cnt, r_i, r_run;
    logic [FRAME_W-1:0] r_frame;
    logic r_user;
    logic [PG_W-1:0] r_pg, r_start;
    logic [CNT_W-1:0] r_end;
    logic r_rdv;
    logic [PG_W-1:0] r_rdpg;
    logic r_ovalid;
    logic [31:0] r_pa, r_base;
    logic r_pres, r_stat;

    logic we;
    logic [PIDX_W-1:0] waddr, raddr;
    t_entry wdata, rdata;
    logic [PG_W-1:0] pg_i;
    logic in_acc, wcyc;

    ptma_ram #(.WIDTH(ENT_W), .DEPTH(VPAGES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign pready = 1'b1;
    assign wcyc = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[3:2])
            REG_KFIRST: prdata = {19'd0, r_kf};
            REG_KEND:   prdata = {19'd0, r_ke};
            REG_UFIRST: prdata = {19'd0, r_uf};
            default:    prdata = {19'd0, r_ue};
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {r_base, r_pa};
    assign m_axis_tuser = {r_stat, r_pres};

    function automatic logic [CNT_W-1:0] clampp(input logic [CNT_W-1:0] p);
        return (p > CNT_W'(VPAGES)) ? CNT_W'(VPAGES) : p;
    endfunction

    assign pg_i = r_pg + PG_W'(r_i);
    logic rd_absent;
    assign rd_absent = (r_rdpg >= PG_W'(VPAGES)) || !rdata.present;

    always_comb begin
        we = 1'b0;
        waddr = pg_i[PIDX_W-1:0];
        wdata = '{present: 1'b1, user: r_user, frame: r_frame + FRAME_W'(r_i)};
        raddr = in_acc ? s_axis_tdata[2+12 +: PIDX_W] : pg_i[PIDX_W-1:0];
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                waddr = r_i[PIDX_W-1:0];
                wdata = '0;
                if (r_i == CNT_W'(VPAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (in_acc) begin
                unique case (s_axis_tdata[1:0])
                    OP_XLATE: n_state = S_XLT;
                    OP_MAP:   n_state = S_WR;
                    OP_UNMAP: n_state = S_UNM;
                    default:  n_state = S_SCAN;
                endcase
            end
            S_XLT: n_state = S_OUT;
            S_WR: begin
                if (r_i == r_cnt) n_state = S_OUT;
                else we = pg_i < PG_W'(VPAGES);
            end
            S_UNM: begin
                if (r_rdv && !rd_absent) begin
                    we = 1'b1;
                    waddr = r_rdpg[PIDX_W-1:0];
                    wdata = '0;
                end
                if (r_i == r_cnt && !r_rdv) n_state = S_OUT;
            end
            S_SCAN: begin
                raddr = r_pg[PIDX_W-1:0];
                if (r_rdv && rd_absent && r_run + 1'b1 == r_cnt) n_state = S_WR;
                else if (r_cnt == '0 || (!r_rdv && r_pg >= PG_W'(r_end))) n_state = S_OUT;
            end
            default: if (m_axis_tready) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i <= '0;
            r_rdv <= 1'b0;
            r_ovalid <= 1'b0;
            r_kf <= CNT_W'(4);
            r_ke <= CNT_W'(1024);
            r_uf <= CNT_W'(1024);
            r_ue <= CNT_W'(4096);
        end else begin
            r_state <= n_state;
            if (wcyc) begin
                unique case (paddr[3:2])
                    REG_KFIRST: r_kf <= pwdata[CNT_W-1:0];
                    REG_KEND:   r_ke <= pwdata[CNT_W-1:0];
                    REG_UFIRST: r_uf <= pwdata[CNT_W-1:0];
                    default:    r_ue <= pwdata[CNT_W-1:0];
                endcase
            end
            if (m_axis_tready && r_ovalid) r_ovalid <= 1'b0;
            r_rdv <= 1'b0;
            unique case (r_state)
                S_CLR: r_i <= r_i + 1'b1;
                S_IDLE: if (in_acc) begin
                    r_va <= s_axis_tdata[33:2];
                    r_cnt <= s_axis_tdata[46:34];
                    r_frame <= s_axis_tdata[66:47];
                    r_user <= s_axis_tuser;
                    r_pg <= s_axis_tdata[33:14];
                    r_rdpg <= s_axis_tdata[33:14];
                    r_i <= '0;
                    r_run <= '0;
                    r_pa <= '0;
                    r_pres <= 1'b0;
                    r_base <= '0;
                    r_stat <= 1'b0;
                    if (s_axis_tdata[1:0] == OP_ALLOC) begin
                        r_pg <= PG_W'(clampp(s_axis_tuser ? r_uf : r_kf));
                        r_end <= clampp(s_axis_tuser ? r_ue : r_ke);
                    end
                end
                S_XLT: begin
                    r_ovalid <= 1'b1;
                    if (!rd_absent) begin
                        r_pres <= 1'b1;
                        r_pa <= {rdata.frame, r_va[11:0]};
                    end
                end
                S_WR: begin
                    if (r_i == r_cnt) r_ovalid <= 1'b1;
                    else r_i <= r_i + 1'b1;
                end
                S_UNM: if (r_i != r_cnt) begin
                    r_rdv <= 1'b1;
                    r_rdpg <= pg_i;
                    r_i <= r_i + 1'b1;
                end else if (!r_rdv) r_ovalid <= 1'b1;
                S_SCAN: begin
                    if (r_rdv) begin
                        if (rd_absent) begin
                            if (r_run == '0) r_start <= r_rdpg;
                            r_run <= r_run + 1'b1;
                            if (r_run + 1'b1 == r_cnt) begin
                                r_pg <= (r_run == '0) ? r_rdpg : r_start;
                                r_base <= {((r_run == '0) ? r_rdpg : r_start), 12'd0};
                                r_i <= '0;
                            end
                        end else r_run <= '0;
                    end
                    if (!(r_rdv && rd_absent && r_run + 1'b1 == r_cnt)) begin
                        if (r_cnt == '0 || (!r_rdv && r_pg >= PG_W'(r_end))) begin
                            r_stat <= 1'b1;
                            r_ovalid <= 1'b1;
                        end else if (r_pg < PG_W'(r_end)) begin
                            r_rdv <= 1'b1;
                            r_rdpg <= r_pg;
                            r_pg <= r_pg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/ptma_checker.sv
// Port-level assertions for the page table map and allocate block, with its bind.
module ptma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata[63:32] == 32'd0)
        else $error("translate result carries allocate fields");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
        else $error("failed allocate carries data");
endmodule

bind page_table_map_and_allocate ptma_checker u_ptma_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

### sim/page_table_map_and_allocate_test.sv
// Testbench for the page table map and allocate block against a local page store model.
module page_table_map_and_allocate_test;
    import ptma_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] vaddr;
        logic [12:0] count;
        logic [19:0] frame;
        logic        user;
    } t_req;

    typedef struct packed {
        logic [31:0] paddr;
        logic        present;
        logic [31:0] base;
        logic        status;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    page_table_map_and_allocate dut (.*);

    always #5 i_clk = ~i_clk;

    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    t_entry page_store[VPAGES];
    logic [12:0] win_reg[4];
    int     fail_count = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     hold_off = 0;
    bit     long_hold_req = 0;

    function automatic int clamp_page(logic [12:0] p);
        return (p > VPAGES) ? VPAGES : int'(p);
    endfunction

    function automatic void map_pages(int page, int count, logic [19:0] frame, logic user);
        int p;
        for (int i = 0; i < count; i++) begin
            p = (page + i) & 32'hfffff;
            if (p < VPAGES) begin
                page_store[p] = '{present: 1'b1, user: user, frame: frame + 20'(i)};
            end
        end
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int page;
        int first;
        int last;
        int run;
        int start;
        bit found;
        rsp = '0;
        page = int'(r.vaddr[31:12]);
        run = 0;
        start = 0;
        found = 0;
        case (r.op)
            OP_XLATE: begin
                if (page < VPAGES && page_store[page].present) begin
                    rsp.paddr = {page_store[page].frame, r.vaddr[11:0]};
                    rsp.present = 1'b1;
                end
            end
            OP_MAP: map_pages(page, int'(r.count), r.frame, r.user);
            OP_UNMAP: begin
                for (int i = 0; i < int'(r.count); i++) begin
                    if (((page + i) & 32'hfffff) < VPAGES) begin
                        page_store[(page + i) & 32'hfffff] = '0;
                    end
                end
            end
            default: begin
                first = clamp_page(r.user ? win_reg[REG_UFIRST] : win_reg[REG_KFIRST]);
                last = clamp_page(r.user ? win_reg[REG_UEND] : win_reg[REG_KEND]);
                if (r.count != 0) begin
                    for (int p = first; p < last && !found; p++) begin
                        if (!page_store[p].present) begin
                            if (run == 0) start = p;
                            run++;
                            if (run == int'(r.count)) found = 1;
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    map_pages(start, int'(r.count), r.frame, r.user);
                    rsp.base = 32'(start) << 12;
                end else begin
                    rsp.status = 1'b1;
                end
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_rsps.push_back(apply_request(pending_reqs[0]));
            void'(pending_reqs.pop_front());
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (gap_left > 0 && burst_left == 0 && !long_hold_req) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {5'b0, pending_reqs[0].frame, pending_reqs[0].count,
                                 pending_reqs[0].vaddr, pending_reqs[0].op};
                s_axis_tuser <= pending_reqs[0].user;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_rsps.size() == 0) begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (m_axis_tdata[31:0] !== exp_rsp.paddr) begin
                    $error("physical_address expected %h actual %h",
                           exp_rsp.paddr, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_rsp.present) begin
                    $error("present expected %b actual %b", exp_rsp.present, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== exp_rsp.base) begin
                    $error("allocated_base expected %h actual %h",
                           exp_rsp.base, m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== exp_rsp.status) begin
                    $error("status expected %b actual %b", exp_rsp.status, m_axis_tuser[1]);
                    fail_count++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req) begin
            hold_off <= 400;
            long_hold_req <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 7) || (($urandom % 64) < 8);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        win_reg[idx] = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_req(logic [1:0] op, logic [31:0] va, logic [12:0] cnt,
                           logic [19:0] fr, logic usr);
        pending_reqs.push_back('{op: op, vaddr: va, count: cnt, frame: fr, user: usr});
    endtask

    task automatic drain_block();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [1:0]  op;
        logic [31:0] va;
        logic [12:0] cnt;
        for (int i = 0; i < n; i++) begin
            op = 2'($urandom_range(0, 3));
            va = ($urandom_range(0, 9) == 0) ? $urandom : {12'($urandom_range(0, 1)),
                 8'($urandom), 12'($urandom)};
            cnt = ($urandom_range(0, 19) == 0) ? 13'($urandom) : 13'($urandom_range(0, 8));
            if (op == OP_UNMAP && $urandom_range(0, 3) == 0) cnt = 13'($urandom_range(0, 64));
            add_req(op, va, cnt, 20'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        win_reg[REG_KFIRST] = 13'd4;
        win_reg[REG_KEND] = 13'd1024;
        win_reg[REG_UFIRST] = 13'd1024;
        win_reg[REG_UEND] = 13'd4096;
        foreach (page_store[i]) page_store[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_req(OP_XLATE, 32'h0000_5abc, 13'd0, 20'd0, 1'b0);
        add_req(OP_MAP, 32'h0000_5000, 13'd3, 20'hffffe, 1'b1);
        add_req(OP_XLATE, 32'h0000_7fff, 13'd0, 20'd0, 1'b0);
        add_req(OP_MAP, 32'h0000_6000, 13'd0, 20'h12345, 1'b0);
        add_req(OP_MAP, 32'h0000_6000, 13'd1, 20'h00001, 1'b0);
        add_req(OP_XLATE, 32'h0000_6123, 13'd0, 20'd0, 1'b1);
        add_req(OP_MAP, 32'hffff_f000, 13'd3, 20'h00010, 1'b0);
        add_req(OP_XLATE, 32'h0000_1000, 13'd0, 20'd0, 1'b0);
        add_req(OP_XLATE, 32'hffff_ffff, 13'd0, 20'd0, 1'b0);
        add_req(OP_MAP, 32'h00ff_f000, 13'd2, 20'h0, 1'b0);
        add_req(OP_UNMAP, 32'h0000_5000, 13'd2, 20'h0, 1'b0);
        add_req(OP_UNMAP, 32'h0000_5000, 13'd4, 20'h0, 1'b0);
        add_req(OP_UNMAP, 32'h0000_5000, 13'd0, 20'h0, 1'b0);
        add_req(OP_ALLOC, 32'h0, 13'd0, 20'h0, 1'b0);
        add_req(OP_ALLOC, 32'h0, 13'd2, 20'h00abc, 1'b0);
        add_req(OP_ALLOC, 32'h0, 13'd3, 20'hfffff, 1'b1);
        add_req(OP_ALLOC, 32'h0, 13'd4096, 20'h0, 1'b1);
        add_req(OP_ALLOC, 32'h0, 13'h1fff, 20'h0, 1'b0);
        add_req(OP_XLATE, 32'h0040_0fff, 13'd0, 20'd0, 1'b0);
        drain_block();

        write_reg(REG_KFIRST, 13'd0);
        write_reg(REG_KEND, 13'h1fff);
        write_reg(REG_UFIRST, 13'd4090);
        write_reg(REG_UEND, 13'd4096);
        random_phase(400);
        long_hold_req = 1;
        drain_block();

        write_reg(REG_KFIRST, 13'd100);
        write_reg(REG_KEND, 13'd50);
        write_reg(REG_UFIRST, 13'h1fff);
        write_reg(REG_UEND, 13'h1fff);
        add_req(OP_ALLOC, 32'h0, 13'd1, 20'h0, 1'b0);
        add_req(OP_ALLOC, 32'h0, 13'd1, 20'h0, 1'b1);
        random_phase(300);
        drain_block();

        write_reg(REG_KFIRST, 13'd8);
        write_reg(REG_KEND, 13'd40);
        write_reg(REG_UFIRST, 13'd40);
        write_reg(REG_UEND, 13'd80);
        random_phase(400);
        drain_block();

        write_reg(REG_KFIRST, 13'd4);
        write_reg(REG_KEND, 13'd1024);
        write_reg(REG_UFIRST, 13'd1024);
        write_reg(REG_UEND, 13'd4096);
        random_phase(430);
        drain_block();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #500_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
